### hw/rtl/range_frame_depth_parser_macros.svh
// Assertion macros used by the range frame parser checker.
`ifndef RANGE_FRAME_DEPTH_PARSER_MACROS_SVH
`define RANGE_FRAME_DEPTH_PARSER_MACROS_SVH

// Checked outside reset only.
`define RFDP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RFDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/rfdp_pkg.sv
// Types, constants and register indexes of the range frame parser.
package rfdp_pkg;

  typedef logic [7:0]  rx_byte_t;
  typedef logic [13:0] range_t;
  typedef logic [21:0] dist_t;
  typedef logic [23:0] depth_t;
  typedef logic [1:0]  status_t;
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [23:0] cfg_data_t;

  localparam int DIGITS_PER_FRAME_DEF = 4;

  localparam rx_byte_t START_CHAR = 8'h52;
  localparam rx_byte_t CHAR_0     = 8'h30;
  localparam rx_byte_t CHAR_9     = 8'h39;

  localparam range_t RANGE_MAX = 14'd16383;

  // ceil(2^32 / 127): exact floor division by 127 for products below 2^25
  localparam logic [25:0] DIV127_MAGIC = 26'd33818641;

  localparam cfg_idx_t CFG_IMPERIAL_MODE = 2'd0;
  localparam cfg_idx_t CFG_TOTAL_LENGTH  = 2'd1;
  localparam cfg_idx_t CFG_MIN_RANGE     = 2'd2;
  localparam cfg_idx_t CFG_NO_TARGET     = 2'd3;

  localparam logic   IMPERIAL_RST     = 1'b1;
  localparam depth_t TOTAL_LENGTH_RST = 24'd12288;
  localparam range_t MIN_RANGE_RST    = 14'd500;
  localparam range_t NO_TARGET_RST    = 14'd5000;

  localparam status_t STATUS_NORMAL    = 2'd0;
  localparam status_t STATUS_TOO_CLOSE = 2'd1;
  localparam status_t STATUS_NO_TARGET = 2'd2;

endpackage

### hw/rtl/rfdp_if.sv
// Valid/ready channel interfaces for received bytes and range results.
interface rfdp_in_if import rfdp_pkg::*; ();
  logic     valid;
  logic     ready;
  rx_byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfdp_out_if import rfdp_pkg::*; ();
  logic    valid;
  logic    ready;
  range_t  decoded_mm;
  dist_t   distance_q8;
  depth_t  depth_q8;
  status_t range_status;

  modport source (output valid, output decoded_mm, output distance_q8, output depth_q8,
                  output range_status, input ready);
  modport sink   (input valid, input decoded_mm, input distance_q8, input depth_q8,
                  input range_status, output ready);
endinterface

### hw/rtl/range_frame_depth_parser.sv
// Range frame parser: ASCII 'R'+digits frames to range, distance, depth and status.
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------
//   in_ch   | sink      | rx_byte
//   out_ch  | source    | decoded_mm, distance_q8, depth_q8, range_status
//   cfg_*   | write     | cfg_index selects register, cfg_wdata holds value
//
// One byte can be accepted every cycle while the input is ready. A result passes
// stage 1 (range latched), stage 2 (distance, in imperial mode by the multiply by
// the reciprocal of 127, and status) and the output register (depth subtract).
// Stages hold when the next one is full and stalled; bytes keep flowing while
// a result waits, until a second and third finished result back up behind it.
// Reset (rst_n low at a clock edge) drops any frame and loads register defaults.
module range_frame_depth_parser import rfdp_pkg::*; #(
  parameter int DIGITS_PER_FRAME = DIGITS_PER_FRAME_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  rfdp_in_if.sink       in_ch,
  rfdp_out_if.source    out_ch,
  input  logic          cfg_we,
  input  cfg_idx_t      cfg_index,
  input  cfg_data_t     cfg_wdata
);

  localparam int CNT_W = (DIGITS_PER_FRAME > 1) ? $clog2(DIGITS_PER_FRAME) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIGITS_PER_FRAME - 1);

  // Configuration registers
  logic   imperial_r;
  depth_t total_len_r;
  range_t min_range_r;
  range_t no_target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imperial_r  <= IMPERIAL_RST;
      total_len_r <= TOTAL_LENGTH_RST;
      min_range_r <= MIN_RANGE_RST;
      no_target_r <= NO_TARGET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMPERIAL_MODE: imperial_r  <= cfg_wdata[0];
        CFG_TOTAL_LENGTH:  total_len_r <= cfg_wdata;
        CFG_MIN_RANGE:     min_range_r <= cfg_wdata[13:0];
        CFG_NO_TARGET:     no_target_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and advance
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_free, s2_free, s1_free;
  logic adv1, adv2;
  logic in_acc;

  assign out_free = !out_v_r || out_ch.ready;
  assign adv2     = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign adv1     = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ch.ready = s1_free;
  assign in_acc   = in_ch.valid && s1_free;

  // Frame parser
  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  range_t           accum_r, accum_nxt;
  logic             is_digit;
  logic [3:0]       digit_val;
  logic [17:0]      acc_ext;
  range_t           acc_sat;
  logic             frame_done;

  assign is_digit  = in_ch.rx_byte inside {[CHAR_0:CHAR_9]};
  assign digit_val = 4'(in_ch.rx_byte - CHAR_0);
  assign acc_ext   = 18'({accum_r, 3'b000}) + 18'({accum_r, 1'b0}) + 18'(digit_val);
  assign acc_sat   = (acc_ext > 18'(RANGE_MAX)) ? RANGE_MAX : acc_ext[13:0];

  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    accum_nxt    = accum_r;
    frame_done   = 1'b0;
    if (in_acc) begin
      if (!in_frame_r) begin
        if (in_ch.rx_byte == START_CHAR) begin
          in_frame_nxt = 1'b1;
          cnt_nxt      = '0;
          accum_nxt    = '0;
        end
      end else if (!is_digit) begin
        // drop the frame
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
        accum_nxt    = '0;
      end else if (cnt_r == LAST_CNT) begin
        frame_done   = 1'b1;
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
        accum_nxt    = '0;
      end else begin
        cnt_nxt   = cnt_r + 1'b1;
        accum_nxt = acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      accum_r    <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
      accum_r    <= accum_nxt;
    end
  end

  // Stage 1: finished range
  range_t s1_mm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      s1_mm_r <= acc_sat;
    end
  end

  // Stage 2: distance and status
  logic [24:0] mm_x1280;
  logic [50:0] prod;
  dist_t       dist_nxt;
  status_t     status_nxt;
  range_t      s2_mm_r;
  dist_t       s2_dist_r;
  status_t     s2_status_r;

  assign mm_x1280 = {1'b0, s1_mm_r, 10'b0} + {3'b000, s1_mm_r, 8'b0};
  assign prod     = 51'(mm_x1280) * 51'(DIV127_MAGIC);
  assign dist_nxt = imperial_r ? {4'b0000, prod[49:32]} : {s1_mm_r, 8'b0};

  always_comb begin
    if (s1_mm_r <= min_range_r) begin
      status_nxt = STATUS_TOO_CLOSE;
    end else if (s1_mm_r >= no_target_r) begin
      status_nxt = STATUS_NO_TARGET;
    end else begin
      status_nxt = STATUS_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_mm_r     <= s1_mm_r;
      s2_dist_r   <= dist_nxt;
      s2_status_r <= status_nxt;
    end
  end

  // Stage 3: depth, output register
  depth_t  dist_ext;
  depth_t  depth_nxt;
  range_t  out_mm_r;
  dist_t   out_dist_r;
  depth_t  out_depth_r;
  status_t out_status_r;

  assign dist_ext  = {2'b00, s2_dist_r};
  assign depth_nxt = (total_len_r > dist_ext) ? (total_len_r - dist_ext) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_mm_r     <= s2_mm_r;
      out_dist_r   <= s2_dist_r;
      out_depth_r  <= depth_nxt;
      out_status_r <= s2_status_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.decoded_mm   = out_mm_r;
  assign out_ch.distance_q8  = out_dist_r;
  assign out_ch.depth_q8     = out_depth_r;
  assign out_ch.range_status = out_status_r;

endmodule

### hw/rtl/rfdp_checker.sv
// Port-level assertions for the range frame parser, bound to its top level.
`include "range_frame_depth_parser_macros.svh"

module rfdp_checker import rfdp_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input range_t decoded_mm,
  input dist_t  distance_q8
);

  `RFDP_ASSERT_ALWAYS(a_rst_clears_out, clk, !rst_n |=> !out_valid, "valid after reset")
  `RFDP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "word dropped")
  `RFDP_ASSERT(a_hold_mm, clk, rst_n, out_valid && !out_ready |=> $stable(decoded_mm), "word moved")
  `RFDP_ASSERT(a_in_stall, clk, rst_n, !in_ready |-> out_valid && !out_ready, "stray input stall")
  `RFDP_ASSERT(a_dist, clk, rst_n, out_valid |-> distance_q8[21:8] <= decoded_mm, "bad distance")

endmodule

bind range_frame_depth_parser rfdp_checker u_rfdp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .decoded_mm  (out_ch.decoded_mm),
  .distance_q8 (out_ch.distance_q8)
);

### tb/testbench.sv
// Testbench for range_frame_depth_parser: randomized byte stream with a self-checking scoreboard.
`timescale 1ns / 100ps

module testbench import rfdp_pkg::*; ();

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int DIGITS         = DIGITS_PER_FRAME_DEF;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 8;
  localparam int BYTES_PER_PHASE = 130;

  typedef struct packed {
    range_t  decoded_mm;
    dist_t   distance_q8;
    depth_t  depth_q8;
    status_t range_status;
  } range_result_t;

  class range_scoreboard;
    logic          imperial;
    depth_t        total_len;
    range_t        min_range;
    range_t        no_target;
    bit            in_frame;
    int unsigned   digits;
    int unsigned   accum;
    range_result_t expected_q[$];
    int unsigned   fail_count;

    function new();
      imperial   = IMPERIAL_RST;
      total_len  = TOTAL_LENGTH_RST;
      min_range  = MIN_RANGE_RST;
      no_target  = NO_TARGET_RST;
      in_frame   = 1'b0;
      digits     = 0;
      accum      = 0;
      fail_count = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t value);
      case (idx)
        CFG_IMPERIAL_MODE: imperial  = value[0];
        CFG_TOTAL_LENGTH:  total_len = value;
        CFG_MIN_RANGE:     min_range = value[13:0];
        CFG_NO_TARGET:     no_target = value[13:0];
        default: ;
      endcase
    endfunction

    // Advance the frame decoder by one accepted word; queue a result on the last digit.
    function void note_byte(rx_byte_t b);
      int unsigned   dist_val;
      range_result_t r;
      if (!in_frame) begin
        if (b == START_CHAR) begin
          in_frame = 1'b1;
          digits   = 0;
          accum    = 0;
        end
        return;
      end
      if (b < CHAR_0 || b > CHAR_9) begin
        in_frame = 1'b0;
        digits   = 0;
        accum    = 0;
        return;
      end
      accum = accum * 10 + 32'(b - CHAR_0);
      if (accum > 32'(RANGE_MAX)) accum = 32'(RANGE_MAX);
      digits++;
      if (digits < DIGITS) return;

      dist_val = imperial ? (accum * 1280) / 127 : accum * 256;
      r.decoded_mm  = range_t'(accum);
      r.distance_q8 = dist_t'(dist_val);
      r.depth_q8    = (32'(total_len) > dist_val) ? depth_t'(32'(total_len) - dist_val) : '0;
      if (accum <= 32'(min_range))      r.range_status = STATUS_TOO_CLOSE;
      else if (accum >= 32'(no_target)) r.range_status = STATUS_NO_TARGET;
      else                              r.range_status = STATUS_NORMAL;
      expected_q.push_back(r);
      in_frame = 1'b0;
      digits   = 0;
      accum    = 0;
    endfunction

    function void compare_field(string field, int unsigned want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(range_result_t got);
      range_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: decoded_mm %0d", got.decoded_mm);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("decoded_mm", 32'(want.decoded_mm), 32'(got.decoded_mm));
      compare_field("distance_q8", 32'(want.distance_q8), 32'(got.distance_q8));
      compare_field("depth_q8", 32'(want.depth_q8), 32'(got.depth_q8));
      compare_field("range_status", 32'(want.range_status), 32'(got.range_status));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  rfdp_in_if  in_ch ();
  rfdp_out_if out_ch ();

  range_frame_depth_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  range_scoreboard board = new();
  bit              calm;
  int              bytes_sent;
  int              idle_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned near_value(int unsigned t);
    int v;
    v = int'(t) + int'($urandom_range(2)) - 1;
    if (v < 0) v = 0;
    if (v > 9999) v = 9999;
    return v;
  endfunction

  // Bias ranges toward both thresholds so the boundary compares get hit.
  function automatic int unsigned pick_range();
    case ($urandom_range(3))
      0:       return near_value(32'(board.min_range));
      1:       return near_value(32'(board.no_target));
      default: return $urandom_range(9999);
    endcase
  endfunction

  function automatic rx_byte_t non_digit();
    rx_byte_t b;
    if ($urandom_range(3) == 0) return START_CHAR;
    do b = rx_byte_t'($urandom_range(255)); while (b >= CHAR_0 && b <= CHAR_9);
    return b;
  endfunction

  // Hold the word until the block takes it; valid stays high across back-to-back words.
  task automatic send_byte(input rx_byte_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input int unsigned mm);
    int unsigned div;
    div = 1;
    repeat (DIGITS - 1) div *= 10;
    send_byte(START_CHAR);
    for (int i = 0; i < DIGITS; i++) begin
      send_byte(CHAR_0 + rx_byte_t'((mm / div) % 10));
      div /= 10;
    end
  endtask

  task automatic random_traffic(input int n_bytes);
    int goal;
    int sel;
    int k;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        send_frame(pick_range());
      end else if (sel < 88) begin
        k = $urandom_range(DIGITS - 1);
        send_byte(START_CHAR);
        repeat (k) send_byte(CHAR_0 + rx_byte_t'($urandom_range(9)));
        send_byte(non_digit());
      end else begin
        // stray words are mostly ignored; keep them out of the count
        send_byte(rx_byte_t'($urandom_range(255)));
        bytes_sent--;
      end
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_data_t imp, input cfg_data_t total,
                              input cfg_data_t min_mm, input cfg_data_t no_tgt);
    cfg_idx_t  idx[4];
    cfg_data_t val[4];
    idx = '{CFG_IMPERIAL_MODE, CFG_TOTAL_LENGTH, CFG_MIN_RANGE, CFG_NO_TARGET};
    val = '{imp, total, min_mm, no_tgt};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      board.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    repeat (RESET_CYCLES + 1) @(posedge clk);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready)
      board.check_result('{out_ch.decoded_mm, out_ch.distance_q8, out_ch.depth_q8,
                           out_ch.range_status});
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** range_frame_depth_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_IMPERIAL_MODE;
    cfg_wdata     <= '0;
    idle_cycles   <= 0;
    calm          = 1'b0;
    bytes_sent    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset settings.
    send_frame(0);
    send_frame(9999);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CHAR_0 + 8'd5);
    // start char inside a frame drops it; the next digit is ignored
    send_byte(START_CHAR);
    send_byte(CHAR_0 + 8'd1);
    send_byte(START_CHAR);
    send_byte(CHAR_0 + 8'd7);
    send_byte(START_CHAR);
    send_byte(CHAR_0 + 8'd2);
    send_byte(CHAR_0 - 8'd1);
    send_byte(START_CHAR);
    send_byte(CHAR_9 + 8'd1);
    send_byte(START_CHAR);
    send_byte(CHAR_0 + 8'd3);
    send_byte(8'h80);
    send_frame(2500);
    wait_drained();

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      case (phase)
        1: program_regs(24'd0, 24'd0, 24'd0, 24'd0);
        2: program_regs(24'd1, 24'hFFFFFF, 24'd9999, 24'd9999);
        3: program_regs(24'd0, 24'hFFFFFF, 24'd0, 24'd9999);
        // extra bits above the imperial, min-range and no-target register widths must be dropped
        4: program_regs(24'hFFFFFE, 24'h000100, 24'hFFFFFF, 24'hFFC000);
        default: program_regs(cfg_data_t'($urandom), cfg_data_t'($urandom),
                              cfg_data_t'($urandom_range(9999)),
                              cfg_data_t'($urandom_range(9999)));
      endcase
      calm = (phase == 3 || phase == 6);
      random_traffic(BYTES_PER_PHASE);
      wait_drained();
    end

    if (board.pending() != 0) begin
      $error("%0d results never arrived", board.pending());
      board.fail_count++;
    end
    if (board.fail_count == 0) begin
      $display("** range_frame_depth_parser: PASSED **");
    end else begin
      $display("** range_frame_depth_parser: FAILED **");
    end
    $finish;
  end

endmodule
